@@ design/aes128_pkg.sv @@
// Package for the AES-128 block encryption core: S-box table, GF helpers,
// round and key-schedule functions. No dependencies.
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0] byte_t;

  typedef enum logic [0:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic byte_t gf_dbl(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n sits in bits 127-8n
  function automatic byte_t get_byte(block_t s, int unsigned n);
    return s[BlockW-1-8*n -: 8];
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    byte_t a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-32*c -: 32] = {a0 ^ al ^ gf_dbl(a0 ^ a1), a1 ^ al ^ gf_dbl(a1 ^ a2),
                                a2 ^ al ^ gf_dbl(a2 ^ a3), a3 ^ al ^ gf_dbl(a3 ^ a0)};
    end
    return t;
  endfunction

  // next round key from current one and its rcon
  function automatic block_t next_key(block_t k, byte_t rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ design/aes128_block_encrypt_top.sv @@
// Top level of the AES-128 encryption core: APB key registers, whitening
// stage, ten round stages and valid tracking. Depends on aes128_pkg, aes128_round.
`timescale 1ns / 1ps
// Fully unrolled AES-128 pipeline: one beat enters per cycle while it is
// not stalled; a ciphertext passes the whitening stage register and then one
// register per round. The pipeline advances as a whole whenever its last
// stage is empty or being taken, so a stall freezes every stage. The key is
// sampled at the whitening stage; write it only while the core is idle.
module aes128_block_encrypt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);

  localparam int unsigned Stages = aes128_pkg::NumRounds + 1;
  localparam logic [7:0] RconTab [aes128_pkg::NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  logic [63:0] key_high_q, key_low_q;
  logic        wr_en;
  logic        adv;
  logic [Stages-1:0] vld_q, vld_d;
  aes128_pkg::block_t st [Stages];
  aes128_pkg::block_t ky [Stages];
  aes128_pkg::block_t st0_q, ky0_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (wr_en && paddr[2:0] == 3'b000 && paddr[3] == 1'b0) begin
      key_high_q <= pwdata;
    end else if (wr_en && paddr[2:0] == 3'b000 && paddr[3] == 1'b1) begin
      key_low_q <= pwdata;
    end
  end

  always_comb begin
    unique case (aes128_pkg::reg_idx_e'(paddr[3]))
      aes128_pkg::RegKeyHigh: prdata = key_high_q;
      aes128_pkg::RegKeyLow:  prdata = key_low_q;
      default:                prdata = '0;
    endcase
  end

  assign adv         = !vld_q[Stages-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Stages-1];
  assign vld_d       = {vld_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q <= {plain_high_i, plain_low_i} ^ {key_high_q, key_low_q};
      ky0_q <= {key_high_q, key_low_q};
    end
  end

  assign st[0] = st0_q;
  assign ky[0] = ky0_q;

  for (genvar r = 0; r < aes128_pkg::NumRounds; r++) begin : g_round
    aes128_round #(
      .Rcon      (RconTab[r]),
      .LastRound (r == aes128_pkg::NumRounds - 1)
    ) u_round (
      .clk_i   (clk_i),
      .en_i    (adv),
      .state_i (st[r]),
      .key_i   (ky[r]),
      .state_o (st[r+1]),
      .key_o   (ky[r+1])
    );
  end

  assign cipher_high_o = st[Stages-1][127:64];
  assign cipher_low_o  = st[Stages-1][63:0];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cipher_high_o))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled with empty output");
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat lost");

endmodule

@@ design/aes128_round.sv @@
// One registered AES round with its on-the-fly key expansion step.
// Depends on aes128_pkg.
`timescale 1ns / 1ps
module aes128_round #(
  parameter logic [7:0] Rcon = 8'h01,
  parameter bit LastRound = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  aes128_pkg::block_t state_i,
  input  aes128_pkg::block_t key_i,
  output aes128_pkg::block_t state_o,
  output aes128_pkg::block_t key_o
);

  aes128_pkg::block_t state_d, state_q, key_d, key_q, sub_s;

  always_comb begin
    sub_s = aes128_pkg::sub_shift(state_i);
    key_d = aes128_pkg::next_key(key_i, Rcon);
    if (LastRound) begin
      state_d = sub_s ^ key_d;
    end else begin
      state_d = aes128_pkg::mix_columns(sub_s) ^ key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

@@ bench/tb_aes128_block_encrypt_top.sv @@
// Testbench for aes128_block_encrypt_top: APB key writes, random-paced plaintext beats,
// and ciphertext checks against an AES-128 predictor built in this file. Depends on aes128_pkg.
`timescale 1ns / 1ps
module tb_aes128_block_encrypt_top;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } half_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] plain_high_i = '0, plain_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] cipher_high_o, cipher_low_o;

  aes128_block_encrypt_top dut (.*);

  always #4 clk_i = ~clk_i;

  half_pair_t  plain_q[$];
  half_pair_t  cipher_q[$];
  logic [63:0] cur_key_hi = '0, cur_key_lo = '0;
  logic [7:0]  sub_tab [256];
  int          errors = 0;
  int          beats_in = 0, beats_out = 0, key_settings = 0;
  bit          quiet = 1'b0;
  int          src_gap = 0, snk_gap = 0;

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = xtime(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] calc_sub(logic [7:0] x);
    logic [7:0] inv;
    inv = '0;
    for (int y = 1; y < 256; y++) if (gmul(x, y[7:0]) == 8'h01) inv = y[7:0];
    return inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
  endfunction

  function automatic half_pair_t aes_encrypt(logic [63:0] kh, logic [63:0] kl,
                                             logic [63:0] ph, logic [63:0] pl);
    logic [31:0] w [44];
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [7:0]  rc, a0, a1, a2, a3, al;
    logic [31:0] t;
    half_pair_t  res;
    rc = 8'h01;
    w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sub_tab[t[23:16]] ^ rc, sub_tab[t[15:8]], sub_tab[t[7:0]], sub_tab[t[31:24]]};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 8; i++) begin
      st[i] = ph[63-8*i -: 8];
      st[8+i] = pl[63-8*i -: 8];
    end
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) tmp[r+4*c] = sub_tab[st[r+4*((c+r)%4)]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4*c+r] ^= w[4*rnd+c][31-8*r -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // source: hold a beat until accepted, then load the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cipher_q.push_back(aes_encrypt(cur_key_hi, cur_key_lo, plain_high_i, plain_low_i));
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (plain_q.size() > 0) begin
          half_pair_t nx;
          nx = plain_q.pop_front();
          plain_high_i <= nx.hi;
          plain_low_i  <= nx.lo;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // sink: check each ciphertext beat, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        beats_out++;
        if (cipher_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, actual %h %h", $time, cipher_high_o, cipher_low_o);
        end else begin
          half_pair_t ex;
          ex = cipher_q.pop_front();
          if (ex.hi !== cipher_high_o) begin
            errors++;
            $display("%0t: cipher_high expected %h actual %h", $time, ex.hi, cipher_high_o);
          end
          if (ex.lo !== cipher_low_o) begin
            errors++;
            $display("%0t: cipher_low expected %h actual %h", $time, ex.lo, cipher_low_o);
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic apb_write(aes128_pkg::reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(8 * int'(idx)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == aes128_pkg::RegKeyHigh) cur_key_hi = val;
    else cur_key_lo = val;
  endtask

  task automatic apb_check(aes128_pkg::reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= 4'(8 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== val) begin
      errors++;
      $display("%0t: key readback expected %h actual %h", $time, val, prdata);
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_key(logic [63:0] kh, logic [63:0] kl);
    apb_write(aes128_pkg::RegKeyHigh, kh);
    apb_write(aes128_pkg::RegKeyLow, kl);
    apb_check(aes128_pkg::RegKeyHigh, kh);
    apb_check(aes128_pkg::RegKeyLow, kl);
    key_settings++;
  endtask

  task automatic drain();
    while (plain_q.size() > 0 || in_valid_i || cipher_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic push_plain(logic [63:0] h, logic [63:0] l);
    half_pair_t p;
    p.hi = h;
    p.lo = l;
    plain_q.push_back(p);
  endtask

  initial begin
    for (int x = 0; x < 256; x++) sub_tab[x] = calc_sub(x[7:0]);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset key is all zero
    push_plain('0, '0);
    push_plain('1, '1);
    drain();
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    push_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
    push_plain('0, '0);
    push_plain('1, '1);
    push_plain(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    push_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    for (int i = 0; i < 64; i += 8) push_plain(64'h1 << i, 64'h1 << (63 - i));
    drain();
    set_key('1, '1);
    push_plain('0, '0);
    push_plain('1, '1);
    push_plain(64'h8000000000000000, 64'h1);
    drain();
    set_key('0, '1);
    push_plain('1, '0);
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) quiet = 1'b1;
      set_key(rand64(), rand64());
      for (int i = 0; i < 250; i++) push_plain(rand64(), rand64());
      drain();
    end
    $display("Encrypted %0d blocks, %0d ciphertexts checked, under %0d keys.",
             beats_in, beats_out, key_settings + 1);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d ciphertexts outstanding.", cipher_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ aes128_block_encrypt_top.f @@
design/aes128_pkg.sv
design/aes128_round.sv
design/aes128_block_encrypt_top.sv
bench/tb_aes128_block_encrypt_top.sv
